// ===== rtl/core/bresenham_line_rasterizer_core_defines.svh =====
// Assertion macros shared by the checker of the Bresenham line rasterizer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define BRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define BRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

// ===== rtl/core/brl_pkg.sv =====
// Shared constants and control types of the Bresenham line rasterizer.
// Depends on nothing; used by the controller, the datapath and the top level.
package brl_pkg;

  // Default coordinate width in bits.
  localparam int COORD_WIDTH = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new line request
    logic push;   // write the current pixel into the output register
    logic drain;  // the output register is taken this cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;       // the current pixel ends the walk
    logic out_valid;  // the output register holds a pixel
  } status_t;

endpackage

// ===== rtl/core/brl_interfaces.sv =====
// Valid/ready channel interfaces for line requests and pixel results.
// Depends on brl_pkg for the default coordinate width.
interface brl_cmd_if #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] start_x;
  logic [COORD_WIDTH-1:0] start_y;
  logic [COORD_WIDTH-1:0] end_x;
  logic [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface brl_pixel_if #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] pixel_x;
  logic [COORD_WIDTH-1:0] pixel_y;
  logic                   last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== rtl/core/bresenham_line_rasterizer_core.sv =====
// Bresenham line rasterizer: takes one line request and emits every pixel of
// the all-octant line from start to end, one pixel a cycle unless the output
// stalls, marking the last. A request is captured into the walker registers
// and then walked by a single step unit; a line from start to end holds
// max(|dx|,|dy|)+1 pixels. The next request is accepted once the final pixel
// sits in the output register, while it still waits to be taken. Depends on
// brl_pkg and brl_interfaces.
module bresenham_line_rasterizer_core #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  brl_cmd_if.sink   cmd,
  brl_pixel_if.source pix
);

  brl_pkg::cmd_t    dp_cmd;
  brl_pkg::status_t dp_status;

  // Sequencing of request capture, stepping and output handoff.
  brl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_ready (pix.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Walker and output register.
  brl_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (dp_cmd),
    .start_x (cmd.start_x),
    .start_y (cmd.start_y),
    .end_x   (cmd.end_x),
    .end_y   (cmd.end_y),
    .status  (dp_status),
    .pixel_x (pix.pixel_x),
    .pixel_y (pix.pixel_y),
    .last    (pix.last)
  );

  assign pix.valid = dp_status.out_valid;

endmodule

// ===== rtl/core/brl_controller.sv =====
// Controller state machine of the Bresenham line rasterizer.
// Depends on brl_pkg for the command and status types.
module brl_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  brl_pkg::status_t  status,
  output brl_pkg::cmd_t     cmd
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic state;
  logic state_next;

  // Handshake and datapath commands.
  always_comb begin
    in_ready  = (state == StIdle);
    cmd.load  = in_valid && (state == StIdle);
    cmd.push  = (state == StWalk) && (!status.out_valid || out_ready);
    cmd.drain = status.out_valid && out_ready;
  end

  // Next state: walk from request capture until the final pixel is pushed.
  always_comb begin
    state_next = state;
    case (state)
      StIdle: begin
        if (cmd.load) begin
          state_next = StWalk;
        end
      end
      StWalk: begin
        if (cmd.push && status.stop) begin
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/brl_datapath.sv =====
// Datapath of the Bresenham line rasterizer: walker registers, step unit
// and the output register. Depends on brl_pkg for the command and status types.
module brl_datapath #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  brl_pkg::cmd_t          cmd,
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  output brl_pkg::status_t       status,
  output logic [COORD_WIDTH-1:0] pixel_x,
  output logic [COORD_WIDTH-1:0] pixel_y,
  output logic                   last
);

  localparam int ErrWidth = COORD_WIDTH + 2;
  localparam int CmpWidth = COORD_WIDTH + 4;
  localparam int ExtWidth = CmpWidth - COORD_WIDTH;

  logic [COORD_WIDTH-1:0] cur_x;
  logic [COORD_WIDTH-1:0] cur_y;
  logic [COORD_WIDTH-1:0] target_x;
  logic [COORD_WIDTH-1:0] target_y;
  logic [COORD_WIDTH-1:0] delta_x;
  logic [COORD_WIDTH-1:0] delta_y;
  logic [ErrWidth-1:0]    error_term;
  logic                   step_x_negative;
  logic                   step_y_negative;
  logic [COORD_WIDTH-1:0] count;
  logic                   out_valid;

  logic [COORD_WIDTH-1:0] load_dx;
  logic [COORD_WIDTH-1:0] load_dy;
  logic [ErrWidth-1:0]    load_err;
  logic signed [CmpWidth-1:0] doubled;
  logic signed [CmpWidth-1:0] dx_ext;
  logic signed [CmpWidth-1:0] dy_ext;
  logic signed [CmpWidth-1:0] err_ext;
  logic signed [CmpWidth-1:0] err_sum;
  logic                   adv_x;
  logic                   adv_y;
  logic                   done;

  // Absolute deltas and initial error of a new request.
  always_comb begin
    load_dx  = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
    load_dy  = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    load_err = {2'b00, load_dx} - {2'b00, load_dy};
  end

  // One Bresenham step: compare the doubled error against both deltas.
  always_comb begin
    dx_ext  = $signed({{ExtWidth{1'b0}}, delta_x});
    dy_ext  = $signed({{ExtWidth{1'b0}}, delta_y});
    err_ext = $signed({{(CmpWidth-ErrWidth){error_term[ErrWidth-1]}}, error_term});
    doubled = $signed({error_term[ErrWidth-1], error_term[ErrWidth-1],
                       error_term[ErrWidth-2:0], 1'b0});
    adv_x   = doubled > -dy_ext;
    adv_y   = doubled < dx_ext;
    err_sum = err_ext - (adv_x ? dy_ext : '0) + (adv_y ? dx_ext : '0);
    done    = (cur_x == target_x) && (cur_y == target_y);
  end

  // Walker registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x           <= start_x;
      cur_y           <= start_y;
      target_x        <= end_x;
      target_y        <= end_y;
      delta_x         <= load_dx;
      delta_y         <= load_dy;
      error_term      <= load_err;
      step_x_negative <= !(start_x < end_x);
      step_y_negative <= !(start_y < end_y);
      count           <= '0;
    end else if (cmd.push) begin
      count      <= count + 1'b1;
      error_term <= err_sum[ErrWidth-1:0];
      if (adv_x) begin
        cur_x <= step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (adv_y) begin
        cur_y <= step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (cmd.drain) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pixel_x <= cur_x;
      pixel_y <= cur_y;
      last    <= done;
    end
  end

  // The walk ends at the end point, or at the pixel count guard.
  always_comb begin
    status.stop      = done || (&count);
    status.out_valid = out_valid;
  end

endmodule

// ===== rtl/core/brl_checker.sv =====
// Port-level assertions of the Bresenham line rasterizer and their bind.
// Depends on bresenham_line_rasterizer_core_defines.svh for the macros.
`include "bresenham_line_rasterizer_core_defines.svh"

module brl_checker #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input logic                   pix_valid,
  input logic                   pix_ready,
  input logic [COORD_WIDTH-1:0] pixel_x,
  input logic [COORD_WIDTH-1:0] pixel_y,
  input logic                   last
);

  // A stalled pixel holds its payload.
  `BRL_ASSERT_NEXT(a_pix_hold, clk, rst, pix_valid && !pix_ready, pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

  // A captured request keeps the block busy in the following cycle.
  `BRL_ASSERT_NEXT(a_busy_after_req, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // A pixel that is not the last is followed at once by the next one.
  `BRL_ASSERT_NEXT(a_no_gap, clk, rst, pix_valid && pix_ready && !last, pix_valid)

  // While a pixel that is not the last waits, no new request is taken.
  `BRL_ASSERT_NOW(a_no_req_mid_line, clk, rst, pix_valid && !last, !cmd_ready)

endmodule

bind bresenham_line_rasterizer_core brl_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_brl_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pixel_x   (pix.pixel_x),
  .pixel_y   (pix.pixel_y),
  .last      (pix.last)
);

// ===== verif/brl_line_checker.sv =====
// Scoreboard for the Bresenham line rasterizer: watches the request and pixel channels,
// traces each accepted line and compares every pixel taken from the block.
// Depends on brl_pkg for the default coordinate width.
module brl_line_checker #(
  parameter int CW = brl_pkg::COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  logic [CW-1:0] start_x,
  input  logic [CW-1:0] start_y,
  input  logic [CW-1:0] end_x,
  input  logic [CW-1:0] end_y,
  input  logic          pix_valid,
  input  logic          pix_ready,
  input  logic [CW-1:0] pixel_x,
  input  logic [CW-1:0] pixel_y,
  input  logic          last,
  output int            mismatches,
  output int            outstanding,
  output int            pixels_checked,
  output int            lines_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Ring of expected pixels; one line in flight plus a waiting last pixel fits easily.
  localparam int QAW    = 8;
  localparam int QDEPTH = 1 << QAW;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  pixel_t           pending_pixels [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  int               pending_count;
  pixel_t           want;
  int               bad_count;
  int               pixel_count;
  int               line_count;

  // Walk one line the way the block does and queue every pixel it must emit.
  function automatic void trace_line(input coord_t x0, input coord_t y0,
                                     input coord_t x1, input coord_t y1);
    coord_t              cx;
    coord_t              cy;
    coord_t              dx;
    coord_t              dy;
    logic signed [CW+2:0] err;
    logic signed [CW+2:0] dbl;
    logic signed [CW+2:0] sdx;
    logic signed [CW+2:0] sdy;
    logic                neg_x;
    logic                neg_y;
    logic                at_end;
    pixel_t              p;
    cx     = x0;
    cy     = y0;
    dx     = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy     = (y1 >= y0) ? y1 - y0 : y0 - y1;
    neg_x  = !(x0 < x1);
    neg_y  = !(y0 < y1);
    sdx    = $signed({3'b000, dx});
    sdy    = $signed({3'b000, dy});
    err    = sdx - sdy;
    for (int n = 0; n < (1 << CW); n++) begin
      at_end = (cx == x1) && (cy == y1);
      p.x    = cx;
      p.y    = cy;
      p.last = at_end;
      pending_pixels[wr_ptr] = p;
      wr_ptr = wr_ptr + 1'b1;
      pending_count++;
      if (at_end) break;
      // Both comparisons use the doubled error from before this step.
      dbl = err <<< 1;
      if (dbl > -sdy) begin
        err = err - sdy;
        cx  = neg_x ? cx - 1'b1 : cx + 1'b1;
      end
      if (dbl < sdx) begin
        err = err + sdx;
        cy  = neg_y ? cy - 1'b1 : cy + 1'b1;
      end
    end
  endfunction

  // Compare the pixel taken this cycle, then queue the pixels of a new request.
  always @(posedge clk) begin
    if (rst) begin
      wr_ptr         = '0;
      rd_ptr         = '0;
      pending_count  = 0;
      bad_count      = 0;
      pixel_count    = 0;
      line_count     = 0;
      mismatches     <= 0;
      outstanding    <= 0;
      pixels_checked <= 0;
      lines_seen     <= 0;
    end else begin
      if (pix_valid && pix_ready) begin
        pixel_count++;
        if (pending_count == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("[%0t] pixel (%0d,%0d) last=%0b arrived with no line pending",
                     $realtime, pixel_x, pixel_y, last);
        end else begin
          want = pending_pixels[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          pending_count--;
          if (want.x !== pixel_x || want.y !== pixel_y || want.last !== last) begin
            bad_count++;
            if (bad_count <= 10)
              $display("[%0t] pixel mismatch: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                       $realtime, want.x, want.y, want.last, pixel_x, pixel_y, last);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        line_count++;
        trace_line(start_x, start_y, end_x, end_y);
      end
      mismatches     <= bad_count;
      outstanding    <= pending_count;
      pixels_checked <= pixel_count;
      lines_seen     <= line_count;
    end
  end

endmodule

// ===== verif/tb_bresenham_line_rasterizer_core.sv =====
// Testbench top for the Bresenham line rasterizer: clock, reset, line requests and
// output back-pressure, with the verdict taken from brl_line_checker.
// Depends on brl_pkg, brl_interfaces and the rasterizer core.
module tb_bresenham_line_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = brl_pkg::COORD_WIDTH;
  localparam int MAXC      = (1 << CW) - 1;
  localparam int CYCLE_CAP = 500000;
  localparam int HOLD_LEN  = 300;

  typedef logic [CW-1:0] coord_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   pixels_checked;
  int   lines_seen;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  int   hold_left;
  logic hold_armed;
  int   cycles;

  brl_cmd_if   #(.COORD_WIDTH(CW)) cmd ();
  brl_pixel_if #(.COORD_WIDTH(CW)) pix ();

  bresenham_line_rasterizer_core #(.COORD_WIDTH(CW)) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .pix (pix)
  );

  brl_line_checker #(.CW(CW)) u_line_check (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .start_x        (cmd.start_x),
    .start_y        (cmd.start_y),
    .end_x          (cmd.end_x),
    .end_y          (cmd.end_y),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pixel_x        (pix.pixel_x),
    .pixel_y        (pix.pixel_y),
    .last           (pix.last),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .pixels_checked (pixels_checked),
    .lines_seen     (lines_seen)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("Timeout after %0d cycles with %0d pixels still expected", cycles, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  // Pixel sink: random stalls, plus one long hold-off counted here once requested.
  always @(posedge clk) begin
    if (rst) begin
      pix.ready  <= 1'b0;
      hold_left  = 0;
      hold_armed = 1'b0;
    end else if (hold_req && !hold_armed) begin
      hold_armed = 1'b1;
      hold_left  = HOLD_LEN;
      pix.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pix.ready <= 1'b0;
    end else begin
      pix.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one line request after a random gap and wait until it is taken.
  task automatic send_line(input coord_t x0, input coord_t y0,
                           input coord_t x1, input coord_t y1);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.start_x <= x0;
    cmd.start_y <= y0;
    cmd.end_x   <= x1;
    cmd.end_y   <= y1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // Pick a random line: short, axis-aligned, diagonal, corner-to-corner or free.
  task automatic pick_line(output coord_t x0, output coord_t y0,
                           output coord_t x1, output coord_t y1);
    int     kind;
    int     hi;
    int     d;
    coord_t t;
    x0   = coord_t'($urandom_range(MAXC));
    y0   = coord_t'($urandom_range(MAXC));
    x1   = coord_t'($urandom_range(MAXC));
    y1   = coord_t'($urandom_range(MAXC));
    kind = int'($urandom_range(99));
    if (kind < 30) begin
      // Short lines, including zero length; these may wrap to long ones at the edges.
      x1 = x0 + coord_t'($urandom_range(6)) - coord_t'(3);
      y1 = y0 + coord_t'($urandom_range(6)) - coord_t'(3);
    end else if (kind < 38) begin
      x1 = x0;
    end else if (kind < 46) begin
      y1 = y0;
    end else if (kind < 54) begin
      hi = (x0 > y0) ? int'(x0) : int'(y0);
      d  = int'($urandom_range(MAXC - hi));
      x1 = x0 + coord_t'(d);
      y1 = y0 + coord_t'(d);
      if ($urandom_range(1)) begin
        t  = x0;
        x0 = x1;
        x1 = t;
      end
    end else if (kind < 64) begin
      x0 = $urandom_range(1) ? coord_t'(MAXC) : '0;
      y0 = $urandom_range(1) ? coord_t'(MAXC) : '0;
      x1 = $urandom_range(1) ? coord_t'(MAXC) : '0;
      y1 = $urandom_range(1) ? coord_t'(MAXC) : '0;
    end
  endtask

  // Stimulus: directed lines, three idle mixes of random lines, one long output hold.
  initial begin
    coord_t dir_lines [22][4] = '{
      '{0, 0, 0, 0},     '{63, 63, 63, 63}, '{0, 0, 63, 0},    '{63, 0, 0, 0},
      '{0, 0, 0, 63},    '{5, 63, 5, 0},    '{0, 0, 63, 63},   '{63, 63, 0, 0},
      '{0, 63, 63, 0},   '{63, 0, 0, 63},   '{10, 10, 40, 20}, '{10, 10, 20, 40},
      '{40, 20, 10, 10}, '{20, 40, 10, 10}, '{10, 40, 40, 30}, '{40, 10, 10, 20},
      '{30, 10, 20, 40}, '{20, 40, 30, 10}, '{32, 32, 33, 33}, '{21, 42, 42, 21},
      '{42, 21, 21, 42}, '{0, 63, 1, 0}
    };
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;

    rst           = 1'b1;
    hold_req      = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 52;
    cmd.valid     = 1'b0;
    cmd.start_x   = '0;
    cmd.start_y   = '0;
    cmd.end_x     = '0;
    cmd.end_y     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: single points, full-span axes and diagonals, all octants.
    foreach (dir_lines[i])
      send_line(dir_lines[i][0], dir_lines[i][1], dir_lines[i][2], dir_lines[i][3]);

    // Random lines with a busy sender and a stalling receiver.
    repeat (150) begin
      pick_line(a, b, c, d);
      send_line(a, b, c, d);
    end

    // Long output hold while requests keep coming, so the input backs up.
    hold_req = 1'b1;
    repeat (8) begin
      pick_line(a, b, c, d);
      send_line(a, b, c, d);
    end

    // Sender pauses until every pixel so far has been taken.
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    // Random lines with a gappy sender and an eager receiver.
    send_idle_pct = 52;
    recv_idle_pct = 9;
    repeat (150) begin
      pick_line(a, b, c, d);
      send_line(a, b, c, d);
    end

    // Random lines back to back with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (140) begin
      pick_line(a, b, c, d);
      send_line(a, b, c, d);
    end

    // Drain and let the block settle before the verdict.
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (70) @(posedge clk);

    $display("Covered %0d line requests (points, axes, diagonals, all octants, random)",
             lines_seen);
    $display("and %0d pixels under three stall mixes and one long output hold.",
             pixels_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
